>>> design/whs_pkg.sv
// ---------------------------------------------------------------------------
// whs_pkg
// Types, op codes and fixed constants of the weighted histogram sampler.
// ---------------------------------------------------------------------------
`default_nettype none

package whs_pkg;

   // Field widths fixed by the item formats
   localparam int WEIGHT_BITS = 16;
   localparam int RANDOM_BITS = 31;
   localparam int PCT_BITS    = 7;

   localparam logic [PCT_BITS-1:0] PERCENT_SPAN = 7'd100;
   localparam logic [PCT_BITS-1:0] WIDTH_RESET  = 7'd10;

   localparam logic STATUS_OK   = 1'b0;
   localparam logic STATUS_FULL = 1'b1;

   typedef enum logic [1:0] {
      OP_CLEAR  = 2'd0,
      OP_APPEND = 2'd1,
      OP_SAMPLE = 2'd2,
      OP_NOP    = 2'd3
   } op_type;

   typedef struct packed {
      op_type                 op;
      logic [WEIGHT_BITS-1:0] weight;
      logic [RANDOM_BITS-1:0] random_word;
   } req_item_type;

   typedef struct packed {
      logic [PCT_BITS-1:0] utilization;
      logic                status;
   } rsp_item_type;

   // Number of whole buckets of the given width in 0..100 percent.
   // A width of zero counts as one.
   function automatic logic [PCT_BITS-1:0] buckets_in_span(input logic [PCT_BITS-1:0] width);
      logic [PCT_BITS-1:0] n;
      priority if (width <= 7'd1)  n = 7'd100;
      else if (width == 7'd2)      n = 7'd50;
      else if (width == 7'd3)      n = 7'd33;
      else if (width == 7'd4)      n = 7'd25;
      else if (width == 7'd5)      n = 7'd20;
      else if (width == 7'd6)      n = 7'd16;
      else if (width == 7'd7)      n = 7'd14;
      else if (width == 7'd8)      n = 7'd12;
      else if (width == 7'd9)      n = 7'd11;
      else if (width == 7'd10)     n = 7'd10;
      else if (width == 7'd11)     n = 7'd9;
      else if (width == 7'd12)     n = 7'd8;
      else if (width <= 7'd14)     n = 7'd7;
      else if (width <= 7'd16)     n = 7'd6;
      else if (width <= 7'd20)     n = 7'd5;
      else if (width <= 7'd25)     n = 7'd4;
      else if (width <= 7'd33)     n = 7'd3;
      else if (width <= 7'd50)     n = 7'd2;
      else if (width <= 7'd100)    n = 7'd1;
      else                         n = 7'd0;
      return n;
   endfunction

endpackage

`default_nettype wire

>>> design/weighted_histogram_sampler.sv
// ---------------------------------------------------------------------------
// weighted_histogram_sampler
// Bucket weight table in a synchronous memory with a weighted random draw.
// ---------------------------------------------------------------------------
//
//   channel  dir  handshake           payload
//   req      in   req_valid/req_stall req_data (op, weight, random_word)
//   rsp      out  rsp_valid/rsp_stall rsp_data (utilization, status)
//   csr      in   csr_valid/csr_ready csr_data (bucket_width)
//
// One item at a time. Clear, append, the unused op and a sample with no usable
// bucket go straight to the result state. A sample first scales the range with
// two divisions when the total exceeds one, then walks the buckets until one
// reaches the rank or none is left: the shared divider retires one quotient bit
// a cycle and the table memory gives one weight a cycle.
// Synchronous reset empties the table and sets the bucket width to 10.
// A finished item waits in the output register while rsp_stall is high;
// req_stall is high whenever an item is in work.
// ---------------------------------------------------------------------------
`default_nettype none

module weighted_histogram_sampler import whs_pkg::*; #(
   parameter int MAX_BUCKETS = 100
) (
   input  wire                 clock,
   input  wire                 reset,
   input  wire                 req_valid,
   output logic                req_stall,
   input  req_item_type        req_data,
   output logic                rsp_valid,
   input  wire                 rsp_stall,
   output rsp_item_type        rsp_data,
   input  wire                 csr_valid,
   output logic                csr_ready,
   input  wire [PCT_BITS-1:0]  csr_data
);

   localparam int CNT_BITS   = $clog2(MAX_BUCKETS + 1);
   localparam int IDX_BITS   = (MAX_BUCKETS > 1) ? $clog2(MAX_BUCKETS) : 1;
   localparam int TOTAL_BITS = WEIGHT_BITS + CNT_BITS;
   localparam int DIV_BITS   = (TOTAL_BITS > RANDOM_BITS + 1) ? TOTAL_BITS : RANDOM_BITS + 1;
   localparam int STEP_BITS  = $clog2(RANDOM_BITS);
   localparam logic [PCT_BITS-1:0]    MAX_BKT   = PCT_BITS'(MAX_BUCKETS);
   localparam logic [RANDOM_BITS-1:0] RAND_TOP  = {RANDOM_BITS{1'b1}};
   localparam logic [STEP_BITS-1:0]   LAST_STEP = STEP_BITS'(RANDOM_BITS - 1);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIV_SCALE,
      ST_DIV_RANK,
      ST_WALK,
      ST_RESULT
   } state_type;

   // Control registers
   state_type             state_ff, state_in;
   logic [PCT_BITS-1:0]   width_ff, width_in;
   logic [CNT_BITS-1:0]   loaded_ff, loaded_in;
   logic [TOTAL_BITS-1:0] total_ff, total_in;
   logic                  rsp_valid_ff, rsp_valid_in;
   logic                  pend_ff, pend_in;

   // Work registers
   rsp_item_type           rsp_data_ff, rsp_data_in;
   logic [PCT_BITS-1:0]    res_util_ff, res_util_in;
   logic                   res_status_ff, res_status_in;
   logic [RANDOM_BITS-1:0] raw_ff, raw_in;
   logic [RANDOM_BITS-1:0] num_ff, num_in;
   logic [RANDOM_BITS-1:0] quo_ff, quo_in;
   logic [DIV_BITS-1:0]    den_ff, den_in;
   logic [DIV_BITS-1:0]    rem_ff, rem_in;
   logic [STEP_BITS-1:0]   step_ff, step_in;
   logic [DIV_BITS-1:0]    rank_ff, rank_in;
   logic [CNT_BITS-1:0]    walk_n_ff, walk_n_in;
   logic [CNT_BITS-1:0]    issue_ff, issue_in;
   logic [TOTAL_BITS-1:0]  acc_ff, acc_in;
   logic [PCT_BITS-1:0]    base_ff, base_in;

   // Table memory
   logic [WEIGHT_BITS-1:0] bucket_mem [MAX_BUCKETS];
   logic [WEIGHT_BITS-1:0] mem_q_ff;
   logic                   mem_we;
   logic                   rd_en;

   // Derived combinational values
   logic [PCT_BITS-1:0]   span_n;
   logic [PCT_BITS-1:0]   limit7;
   logic [CNT_BITS-1:0]   limit;
   logic [CNT_BITS-1:0]   usable_n;
   logic [PCT_BITS-1:0]   w_eff;
   logic [PCT_BITS:0]     w_plus1;
   logic [PCT_BITS-1:0]   half_w;
   logic                  req_accept;
   logic                  rsp_free;
   logic [DIV_BITS:0]     trial;
   logic [DIV_BITS:0]     diff;
   logic                  fits;
   logic [DIV_BITS-1:0]   rem_next;
   logic [RANDOM_BITS-1:0] quo_next;
   logic [TOTAL_BITS-1:0] acc_sum;

   assign csr_ready  = 1'b1;
   assign req_stall  = (state_ff != ST_IDLE);
   assign req_accept = req_valid && !req_stall;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_data_ff;
   assign rsp_free   = !rsp_valid_ff || !rsp_stall;

   // Bucket geometry from the width register
   assign span_n   = buckets_in_span(width_ff);
   assign limit7   = (span_n > MAX_BKT) ? MAX_BKT : span_n;
   assign limit    = CNT_BITS'(limit7);
   assign usable_n = (loaded_ff < limit) ? loaded_ff : limit;
   assign w_eff    = (width_ff == '0) ? PCT_BITS'(1) : width_ff;
   assign w_plus1  = {1'b0, w_eff} + (PCT_BITS + 1)'(1);
   assign half_w   = w_plus1[PCT_BITS:1];

   // Shared restoring divider, one quotient bit per cycle
   assign trial    = {rem_ff, num_ff[RANDOM_BITS-1]};
   assign diff     = trial - {1'b0, den_ff};
   assign fits     = (trial >= {1'b0, den_ff});
   assign rem_next = fits ? diff[DIV_BITS-1:0] : trial[DIV_BITS-1:0];
   assign quo_next = {quo_ff[RANDOM_BITS-2:0], fits};

   // Running cumulative weight
   assign acc_sum  = acc_ff + TOTAL_BITS'(mem_q_ff);

   // Next-state logic
   always_comb begin
      state_in      = state_ff;
      width_in      = width_ff;
      loaded_in     = loaded_ff;
      total_in      = total_ff;
      rsp_valid_in  = rsp_valid_ff;
      pend_in       = 1'b0;
      rsp_data_in   = rsp_data_ff;
      res_util_in   = res_util_ff;
      res_status_in = res_status_ff;
      raw_in        = raw_ff;
      num_in        = num_ff;
      quo_in        = quo_ff;
      den_in        = den_ff;
      rem_in        = rem_ff;
      step_in       = step_ff;
      rank_in       = rank_ff;
      walk_n_in     = walk_n_ff;
      issue_in      = issue_ff;
      acc_in        = acc_ff;
      base_in       = base_ff;
      mem_we        = 1'b0;
      rd_en         = 1'b0;

      if (csr_valid && csr_ready) begin
         width_in = csr_data;
      end

      // Output register drains when taken
      if (rsp_valid_ff && !rsp_stall) begin
         rsp_valid_in = 1'b0;
      end

      unique case (state_ff)
         ST_IDLE: begin
            if (req_accept) begin
               res_util_in   = '0;
               res_status_in = STATUS_OK;
               state_in      = ST_RESULT;
               unique case (req_data.op)
                  OP_CLEAR: begin
                     loaded_in = '0;
                     total_in  = '0;
                  end
                  OP_APPEND: begin
                     if (loaded_ff >= limit) begin
                        res_status_in = STATUS_FULL;
                     end else begin
                        mem_we    = 1'b1;
                        loaded_in = loaded_ff + CNT_BITS'(1);
                        total_in  = total_ff + TOTAL_BITS'(req_data.weight);
                     end
                  end
                  OP_SAMPLE: begin
                     raw_in    = req_data.random_word;
                     walk_n_in = usable_n;
                     issue_in  = '0;
                     acc_in    = '0;
                     base_in   = '0;
                     if (usable_n == '0) begin
                        res_util_in = PERCENT_SPAN;
                     end else if (total_ff <= TOTAL_BITS'(1)) begin
                        rank_in  = DIV_BITS'(1);
                        state_in = ST_WALK;
                     end else begin
                        // divisor scale: RAND_TOP / total
                        num_in   = RAND_TOP;
                        den_in   = DIV_BITS'(total_ff);
                        rem_in   = '0;
                        quo_in   = '0;
                        step_in  = LAST_STEP;
                        state_in = ST_DIV_SCALE;
                     end
                  end
                  OP_NOP: begin
                  end
               endcase
            end
         end

         ST_DIV_SCALE: begin
            rem_in = rem_next;
            quo_in = quo_next;
            num_in = {num_ff[RANDOM_BITS-2:0], 1'b0};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               // rank: raw / (scale + 1)
               num_in   = raw_ff;
               den_in   = DIV_BITS'(quo_next) + DIV_BITS'(1);
               rem_in   = '0;
               quo_in   = '0;
               step_in  = LAST_STEP;
               state_in = ST_DIV_RANK;
            end
         end

         ST_DIV_RANK: begin
            rem_in = rem_next;
            quo_in = quo_next;
            num_in = {num_ff[RANDOM_BITS-2:0], 1'b0};
            step_in = step_ff - STEP_BITS'(1);
            if (step_ff == '0) begin
               rank_in  = DIV_BITS'(quo_next) + DIV_BITS'(1);
               state_in = ST_WALK;
            end
         end

         ST_WALK: begin
            // issue one table read a cycle, data returns next cycle
            if (issue_ff < walk_n_ff) begin
               rd_en    = 1'b1;
               issue_in = issue_ff + CNT_BITS'(1);
               pend_in  = 1'b1;
            end
            if (pend_ff) begin
               acc_in = acc_sum;
               if (rank_ff <= DIV_BITS'(acc_sum)) begin
                  res_util_in = base_ff + half_w;
                  state_in    = ST_RESULT;
               end else begin
                  base_in = base_ff + w_eff;
               end
            end else if (issue_ff >= walk_n_ff) begin
               res_util_in = PERCENT_SPAN;
               state_in    = ST_RESULT;
            end
         end

         ST_RESULT: begin
            if (rsp_free) begin
               rsp_valid_in            = 1'b1;
               rsp_data_in.utilization = res_util_ff;
               rsp_data_in.status      = res_status_ff;
               state_in                = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // State and registered outputs
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         width_ff     <= WIDTH_RESET;
         loaded_ff    <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         state_ff     <= state_in;
         width_ff     <= width_in;
         loaded_ff    <= loaded_in;
         total_ff     <= total_in;
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
      rsp_data_ff   <= rsp_data_in;
      res_util_ff   <= res_util_in;
      res_status_ff <= res_status_in;
      raw_ff        <= raw_in;
      num_ff        <= num_in;
      quo_ff        <= quo_in;
      den_ff        <= den_in;
      rem_ff        <= rem_in;
      step_ff       <= step_in;
      rank_ff       <= rank_in;
      walk_n_ff     <= walk_n_in;
      issue_ff      <= issue_in;
      acc_ff        <= acc_in;
      base_ff       <= base_in;
   end

   // Weight table: one write port, one registered read port
   always_ff @(posedge clock) begin
      if (mem_we) begin
         bucket_mem[loaded_ff[IDX_BITS-1:0]] <= req_data.weight;
      end
      if (rd_en) begin
         mem_q_ff <= bucket_mem[issue_ff[IDX_BITS-1:0]];
      end
   end

endmodule

`default_nettype wire
